@@ design/xue_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xue_pkg
// Shared types and character constants for the XML entity decoder.
// ----------------------------------------------------------------------------
package xue_pkg;

  localparam logic [7:0] CH_AMP   = 8'h26;  // '&'
  localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
  localparam logic [7:0] CH_QUOT  = 8'h22;  // '"'
  localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
  localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
  localparam logic [7:0] CH_APOS  = 8'h27;  // '\''
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Entity names, first character in the low byte.
  localparam logic [31:0] NAME_AMP  = 32'h0070_6D61;  // "amp"
  localparam logic [31:0] NAME_QUOT = 32'h746F_7571;  // "quot"
  localparam logic [31:0] NAME_LT   = 32'h0000_746C;  // "lt"
  localparam logic [31:0] NAME_GT   = 32'h0000_7467;  // "gt"
  localparam logic [31:0] NAME_APOS = 32'h736F_7061;  // "apos"

  localparam logic [2:0] NAME_MAX = 3'd5;  // saturated: name longer than four

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,   // skipping white space
    PH_DIGITS = 2'd1,   // after sign or digit
    PH_STOP   = 2'd2    // first non-digit seen
  } num_phase_t;

  typedef struct packed {
    logic        in_entity;
    logic [31:0] name_chars;
    logic [2:0]  name_count;
    num_phase_t  number_phase;
    logic        number_negative;
    logic [7:0]  number_value;
  } xue_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       bad_escape;
    logic       string_done;
  } xue_res_t;

  localparam xue_state_t STATE_CLEAR = '{
    in_entity:       1'b0,
    name_chars:      32'd0,
    name_count:      3'd0,
    number_phase:    PH_SKIP,
    number_negative: 1'b0,
    number_value:    8'd0
  };

endpackage

@@ design/xue_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xue_if
// Valid/ready channels for escaped input bytes and decoded result beats.
// ----------------------------------------------------------------------------
interface xue_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface xue_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       bad_escape;
  logic       string_done;

  modport source (output valid, output out_byte, output bad_escape, output string_done,
                  input ready);
  modport sink   (input valid, input out_byte, input bad_escape, input string_done,
                  output ready);
endinterface

@@ design/xue_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xue_step
// Per-byte decode: next entity state and the optional result beat.
// ----------------------------------------------------------------------------
module xue_step
  import xue_pkg::*;
(
  input  xue_state_t st,
  input  logic [7:0] in_byte,
  input  logic       last,
  output xue_state_t st_nxt,
  output logic       emit,
  output xue_res_t   res
);

  logic       is_digit;
  logic       is_space;
  logic [7:0] digit_val;
  logic [7:0] val_x10;
  logic [7:0] resolved;
  logic       is_numeric;

  assign is_digit  = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign is_space  = (in_byte == CH_SPACE) || ((in_byte >= CH_TAB) && (in_byte <= CH_CR));
  assign digit_val = in_byte - CH_ZERO;
  assign val_x10   = {st.number_value[4:0], 3'b000} + {st.number_value[6:0], 1'b0};
  assign is_numeric = (st.name_count != 3'd0) && (st.name_chars[7:0] == CH_HASH);

  // Value of the entity closed by ';'; zero means malformed.
  always_comb begin
    resolved = 8'd0;
    if (is_numeric) begin
      resolved = st.number_negative ? (8'd0 - st.number_value) : st.number_value;
    end else if (st.name_count == 3'd3 && st.name_chars == NAME_AMP) begin
      resolved = CH_AMP;
    end else if (st.name_count == 3'd4 && st.name_chars == NAME_QUOT) begin
      resolved = CH_QUOT;
    end else if (st.name_count == 3'd2 && st.name_chars == NAME_LT) begin
      resolved = CH_LT;
    end else if (st.name_count == 3'd2 && st.name_chars == NAME_GT) begin
      resolved = CH_GT;
    end else if (st.name_count == 3'd4 && st.name_chars == NAME_APOS) begin
      resolved = CH_APOS;
    end
  end

  always_comb begin
    st_nxt = st;
    emit   = 1'b0;
    res    = '{out_byte: in_byte, bad_escape: 1'b0, string_done: last};
    if (st.in_entity) begin
      if (in_byte == CH_AMP) begin
        st_nxt = STATE_CLEAR;
        emit   = 1'b1;
        res    = '{out_byte: 8'd0, bad_escape: 1'b1, string_done: 1'b1};
      end else if (in_byte == CH_SEMI) begin
        st_nxt = STATE_CLEAR;
        emit   = 1'b1;
        if (resolved == 8'd0) begin
          res = '{out_byte: 8'd0, bad_escape: 1'b1, string_done: 1'b1};
        end else begin
          res = '{out_byte: resolved, bad_escape: 1'b0, string_done: last};
        end
      end else begin
        // name byte
        if (st.name_count == 3'd0) begin
          st_nxt.name_chars      = {24'd0, in_byte};
          st_nxt.number_phase    = PH_SKIP;
          st_nxt.number_negative = 1'b0;
          st_nxt.number_value    = 8'd0;
          st_nxt.name_count      = 3'd1;
        end else begin
          if (st.name_chars[7:0] == CH_HASH) begin
            unique case (st.number_phase)
              PH_SKIP: begin
                if (is_space) begin
                  st_nxt.number_phase = PH_SKIP;
                end else if (in_byte == CH_PLUS || in_byte == CH_MINUS) begin
                  st_nxt.number_negative = (in_byte == CH_MINUS);
                  st_nxt.number_phase    = PH_DIGITS;
                end else if (is_digit) begin
                  st_nxt.number_value = digit_val;
                  st_nxt.number_phase = PH_DIGITS;
                end else begin
                  st_nxt.number_phase = PH_STOP;
                end
              end
              PH_DIGITS: begin
                if (is_digit) begin
                  st_nxt.number_value = val_x10 + digit_val;
                end else begin
                  st_nxt.number_phase = PH_STOP;
                end
              end
              default: st_nxt.number_phase = st.number_phase;
            endcase
          end
          unique case (st.name_count)
            3'd1:    st_nxt.name_chars[15:8]  = in_byte;
            3'd2:    st_nxt.name_chars[23:16] = in_byte;
            3'd3:    st_nxt.name_chars[31:24] = in_byte;
            default: st_nxt.name_chars        = st.name_chars;
          endcase
          if (st.name_count < NAME_MAX) begin
            st_nxt.name_count = st.name_count + 3'd1;
          end
        end
        if (last) begin
          st_nxt = STATE_CLEAR;
          emit   = 1'b1;
          res    = '{out_byte: 8'd0, bad_escape: 1'b1, string_done: 1'b1};
        end
      end
    end else if (in_byte == CH_AMP) begin
      st_nxt           = STATE_CLEAR;
      st_nxt.in_entity = 1'b1;
      if (last) begin
        st_nxt = STATE_CLEAR;
        emit   = 1'b1;
        res    = '{out_byte: 8'd0, bad_escape: 1'b1, string_done: 1'b1};
      end
    end else begin
      emit = 1'b1;
    end
  end

endmodule

@@ design/xml_entity_unescape.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_entity_unescape
// Streaming XML character entity decoder, one byte per beat.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                               notes
//  -------  ---  ------------------------------------  -------------------------
//  in_ch    in   in_byte[7:0], end_of_string           one escaped byte per beat
//  out_ch   out  out_byte[7:0], bad_escape, string_done zero or one beat per input
//
//  Cycles: one input beat per clock while in_ch.ready is high; a result
//  appears in the cycle after its input beat, from the result register.
//  The per-byte decode is a single combinational pass from the entity state
//  registers and the input beat to the result register.
//  Reset (rst_n low, synchronous) clears the entity state and the result valid.
//  Stalls: in_ch.ready drops only while a result is held and out_ch.ready is
//  low; a beat that yields no result ('&' or a name byte) still needs ready.
//
module xml_entity_unescape
  import xue_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  xue_in_if.sink       in_ch,
  xue_out_if.source    out_ch
);

  xue_state_t st_r;
  xue_state_t st_nxt;
  logic       emit;
  xue_res_t   res;

  logic       out_valid_r;
  xue_res_t   out_r;
  logic       in_acc;

  // Input is taken whenever the result register is empty or draining.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  xue_step u_step (
    .st      (st_r),
    .in_byte (in_ch.in_byte),
    .last    (in_ch.end_of_string),
    .st_nxt  (st_nxt),
    .emit    (emit),
    .res     (res)
  );

  // Entity state: advances once per accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_CLEAR;
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  // Result register: loads on an accepted beat that produces a result,
  // empties when the sink takes the held beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= emit;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      out_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_r.out_byte;
  assign out_ch.bad_escape  = out_r.bad_escape;
  assign out_ch.string_done = out_r.string_done;

`ifndef SYNTH
  // An error beat carries a zero byte and closes the string.
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.bad_escape) |-> (out_r.out_byte == 8'd0 && out_r.string_done))
    else $error("error beat not zero or not string end");

  // The end of a string never leaves an entity open.
  a_eos_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.end_of_string) |=> !st_r.in_entity)
    else $error("entity left open after end of string");

  // Outside an entity the name state is idle.
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.in_entity |-> (st_r.name_count == 3'd0 && st_r.number_value == 8'd0))
    else $error("stale name state outside entity");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.name_count <= NAME_MAX)
    else $error("name count past saturation");

  // Plain bytes pass straight through on the next cycle.
  a_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !st_r.in_entity && in_ch.in_byte != CH_AMP) |=>
      (out_valid_r && !out_r.bad_escape && out_r.out_byte == $past(in_ch.in_byte)))
    else $error("plain byte not passed through");
`endif

endmodule

@@ sim/tb_xml_entity_unescape.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_xml_entity_unescape
// Self-checking bench for the streaming XML entity decoder. Escaped strings
// go in one byte per beat and each accepted beat is run through a local
// decoder model; every result beat is checked field by field against the
// oldest pending prediction. Both channels idle at random in two of three phases.
// ----------------------------------------------------------------------------
module tb_xml_entity_unescape;
  import xue_pkg::*;

  localparam int STALL_LIMIT  = 2000;  // cycles with no beat on either channel
  localparam int DRAIN_CYCLES = 8;     // result register plus margin

  // Kinds of text segment the random strings are built from.
  typedef enum int {
    SEG_PLAIN,     // ordinary bytes, no '&'
    SEG_NAMED,     // one of the five named entities
    SEG_NUMERIC,   // &#...; with white space, sign, digits, junk
    SEG_BAD_NAME,  // random name bytes, mostly unknown or too long
    SEG_DOUBLE_AMP,// '&' inside an open entity
    SEG_NOISE      // any byte at all, '&' and ';' included
  } seg_kind_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the decoder state, predicted results in order.
  // --------------------------------------------------------------------------
  class unescape_checker;
    xue_state_t st;
    xue_res_t   expected_q[$];
    int         mismatches;
    int         beats_in;
    int         beats_out;
    int         decoded_entities;
    int         bad_escapes;

    function new();
      st = STATE_CLEAR;
    endfunction

    task report(input string msg);
      mismatches++;
      $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // atoi-style step for names that start with '#'
    function void number_step(logic [7:0] b);
      logic is_digit;
      logic is_space;
      is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
      is_space = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
      case (st.number_phase)
        PH_SKIP: begin
          if (is_space)
            return;
          if (b == CH_PLUS || b == CH_MINUS) begin
            st.number_negative = (b == CH_MINUS);
            st.number_phase    = PH_DIGITS;
          end else if (is_digit) begin
            st.number_value = b - CH_ZERO;
            st.number_phase = PH_DIGITS;
          end else begin
            st.number_phase = PH_STOP;
          end
        end
        PH_DIGITS: begin
          if (is_digit)
            st.number_value = st.number_value * 8'd10 + (b - CH_ZERO);
          else
            st.number_phase = PH_STOP;
        end
        default: ;
      endcase
    endfunction

    function void name_step(logic [7:0] b);
      if (st.name_count == 3'd0) begin
        // first name byte restarts the numeric reader too
        st.name_chars      = {24'd0, b};
        st.number_phase    = PH_SKIP;
        st.number_negative = 1'b0;
        st.number_value    = 8'd0;
        st.name_count      = 3'd1;
        return;
      end
      if (st.name_chars[7:0] == CH_HASH)
        number_step(b);
      if (st.name_count < 3'd4)
        st.name_chars[8*st.name_count +: 8] = b;
      if (st.name_count < NAME_MAX)
        st.name_count = st.name_count + 3'd1;
    endfunction

    // Decoded character of the open entity, 0 when the name is no good.
    function logic [7:0] entity_value();
      if (st.name_count >= 3'd1 && st.name_chars[7:0] == CH_HASH)
        return st.number_negative ? 8'd0 - st.number_value : st.number_value;
      if (st.name_count == 3'd3 && st.name_chars == NAME_AMP)  return CH_AMP;
      if (st.name_count == 3'd4 && st.name_chars == NAME_QUOT) return CH_QUOT;
      if (st.name_count == 3'd2 && st.name_chars == NAME_LT)   return CH_LT;
      if (st.name_count == 3'd2 && st.name_chars == NAME_GT)   return CH_GT;
      if (st.name_count == 3'd4 && st.name_chars == NAME_APOS) return CH_APOS;
      return 8'd0;
    endfunction

    function void flag_bad_escape();
      xue_res_t r;
      r.out_byte    = 8'd0;
      r.bad_escape  = 1'b1;
      r.string_done = 1'b1;
      st = STATE_CLEAR;
      bad_escapes++;
      expected_q.push_back(r);
    endfunction

    // Called once per accepted input beat.
    function void take_input_beat(logic [7:0] b, logic last);
      xue_res_t   r;
      logic [7:0] v;
      beats_in++;
      r.out_byte    = b;
      r.bad_escape  = 1'b0;
      r.string_done = last;
      if (st.in_entity) begin
        if (b == CH_AMP) begin
          flag_bad_escape();
          return;
        end
        if (b == CH_SEMI) begin
          v = entity_value();
          if (v == 8'd0) begin
            flag_bad_escape();
            return;
          end
          st = STATE_CLEAR;
          r.out_byte = v;
          decoded_entities++;
          expected_q.push_back(r);
          return;
        end
        name_step(b);
        if (last)
          flag_bad_escape();
        return;
      end
      if (b == CH_AMP) begin
        st = STATE_CLEAR;
        st.in_entity = 1'b1;
        if (last)
          flag_bad_escape();
        return;
      end
      expected_q.push_back(r);
    endfunction

    task check_output_beat(input xue_res_t got);
      xue_res_t want;
      beats_out++;
      if (expected_q.size() == 0) begin
        report($sformatf("result beat with nothing pending: byte=%h bad=%b done=%b",
                         got.out_byte, got.bad_escape, got.string_done));
        return;
      end
      want = expected_q.pop_front();
      if (got.out_byte !== want.out_byte)
        report($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
      if (got.bad_escape !== want.bad_escape)
        report($sformatf("bad_escape %b, want %b", got.bad_escape, want.bad_escape));
      if (got.string_done !== want.string_done)
        report($sformatf("string_done %b, want %b", got.string_done, want.string_done));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  xue_in_if  in_ch ();
  xue_out_if out_ch ();

  xml_entity_unescape dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  unescape_checker board;

  int         src_gap_pct;     // chance per cycle that the sender idles
  int         sink_stall_pct;  // chance per cycle that the receiver stalls
  int         stall_cycles;
  int         random_beats;
  logic [7:0] text_q[$];       // bytes of the string being built

  // --------------------------------------------------------------------------
  // Sender. Called at a rising edge; returns at a rising edge. valid stays
  // high from one beat to the next unless the idle roll drops it.
  // --------------------------------------------------------------------------
  task automatic send_beat(input logic [7:0] b, input logic last);
    in_ch.valid         <= 1'b1;
    in_ch.in_byte       <= b;
    in_ch.end_of_string <= last;
    @(posedge clk);
    while (in_ch.ready !== 1'b1)
      @(posedge clk);
    board.take_input_beat(b, last);
    // idle gap after the beat, garbage on the bus meanwhile
    while ($urandom_range(99) < src_gap_pct) begin
      in_ch.valid         <= 1'b0;
      in_ch.in_byte       <= 8'($urandom);
      in_ch.end_of_string <= 1'($urandom);
      @(posedge clk);
    end
  endtask

  task automatic send_text(input string s, input logic last);
    for (int i = 0; i < s.len(); i++)
      send_beat(s[i], last && (i == s.len() - 1));
  endtask

  // --------------------------------------------------------------------------
  // Random text. Well-formed entities dominate so the numeric reader and the
  // name matcher get exercised; the rest is bad names, stray '&' and noise.
  // --------------------------------------------------------------------------
  function automatic logic [7:0] any_byte_but_markup();
    logic [7:0] b;
    do b = 8'($urandom);
    while (b == CH_AMP || b == CH_SEMI);
    return b;
  endfunction

  function automatic logic [7:0] space_byte();
    int k;
    k = $urandom_range(0, 5);
    return (k == 0) ? CH_SPACE : CH_TAB + 8'(k - 1);
  endfunction

  function automatic void add_segment(seg_kind_t kind);
    logic [31:0] name;
    int          len;
    int          k;
    logic [7:0]  b;
    case (kind)
      SEG_PLAIN: begin
        len = $urandom_range(1, 4);
        repeat (len) begin
          do b = 8'($urandom);
          while (b == CH_AMP);
          text_q.push_back(b);
        end
      end
      SEG_NAMED: begin
        case ($urandom_range(0, 4))
          0:       begin name = NAME_AMP;  len = 3; end
          1:       begin name = NAME_QUOT; len = 4; end
          2:       begin name = NAME_LT;   len = 2; end
          3:       begin name = NAME_GT;   len = 2; end
          default: begin name = NAME_APOS; len = 4; end
        endcase
        text_q.push_back(CH_AMP);
        for (k = 0; k < len; k++)
          text_q.push_back(name[8*k +: 8]);
        // now and then one byte too many, which makes the name unknown
        if ($urandom_range(9) == 0)
          text_q.push_back(any_byte_but_markup());
        text_q.push_back(CH_SEMI);
      end
      SEG_NUMERIC: begin
        text_q.push_back(CH_AMP);
        text_q.push_back(CH_HASH);
        repeat ($urandom_range(0, 2))
          text_q.push_back(space_byte());
        case ($urandom_range(0, 3))
          0:       text_q.push_back(CH_PLUS);
          1:       text_q.push_back(CH_MINUS);
          default: ;
        endcase
        // zero digits can give value zero; three or four digits can wrap past 255
        repeat ($urandom_range(0, 4))
          text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(4) == 0)
          text_q.push_back(any_byte_but_markup());
        if ($urandom_range(4) == 0)
          text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        text_q.push_back(CH_SEMI);
      end
      SEG_BAD_NAME: begin
        text_q.push_back(CH_AMP);
        len = $urandom_range(0, 6);
        repeat (len) begin
          if ($urandom_range(1) == 0)
            text_q.push_back(8'("a") + 8'($urandom_range(0, 25)));
          else
            text_q.push_back(any_byte_but_markup());
        end
        text_q.push_back(CH_SEMI);
      end
      SEG_DOUBLE_AMP: begin
        text_q.push_back(CH_AMP);
        repeat ($urandom_range(0, 2))
          text_q.push_back(any_byte_but_markup());
        text_q.push_back(CH_AMP);
      end
      default: begin
        repeat ($urandom_range(1, 3))
          text_q.push_back(8'($urandom));
      end
    endcase
  endfunction

  function automatic void build_string();
    int        pick;
    seg_kind_t kind;
    text_q.delete();
    repeat ($urandom_range(1, 6)) begin
      pick = $urandom_range(99);
      if (pick < 30)      kind = SEG_PLAIN;
      else if (pick < 52) kind = SEG_NAMED;
      else if (pick < 74) kind = SEG_NUMERIC;
      else if (pick < 86) kind = SEG_BAD_NAME;
      else if (pick < 92) kind = SEG_DOUBLE_AMP;
      else                kind = SEG_NOISE;
      add_segment(kind);
    end
    // sometimes the string stops inside an open entity
    if ($urandom_range(9) == 0) begin
      text_q.push_back(CH_AMP);
      repeat ($urandom_range(0, 3))
        text_q.push_back(any_byte_but_markup());
    end
  endfunction

  task automatic send_random_strings(input int beats);
    int sent;
    sent = 0;
    while (sent < beats) begin
      build_string();
      foreach (text_q[k])
        send_beat(text_q[k], k == text_q.size() - 1);
      sent += text_q.size();
    end
    random_beats += sent;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random back-pressure, every accepted beat goes to the checker.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        board.check_output_beat(xue_res_t'{out_byte:    out_ch.out_byte,
                                           bad_escape:  out_ch.bad_escape,
                                           string_done: out_ch.string_done});
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d results pending",
               STALL_LIMIT, board.expected_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_ch.valid         = 1'b0;
    in_ch.in_byte       = 8'd0;
    in_ch.end_of_string = 1'b0;
    random_beats        = 0;
    board = new();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // phase 1: sender idles lightly, receiver stalls a lot
    src_gap_pct    = 25;
    sink_stall_pct = 45;

    // directed: byte extremes, every named entity, signed numeric form
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_text("&lt;&gt;&amp;", 1'b1);
    send_text("&quot;&apos;", 1'b1);
    send_text("&#\t-7;", 1'b1);
    // '&' inside an entity, empty name, value zero, no digits
    send_text("&a&", 1'b0);
    send_text("&;", 1'b0);
    send_text("&#256;", 1'b0);
    send_text("&#;", 1'b0);
    // string ends on a bare '&'
    send_text("&", 1'b1);

    send_random_strings(115);

    // phase 2: roles swapped
    src_gap_pct    = 45;
    sink_stall_pct = 25;
    send_random_strings(115);

    // phase 3: full rate both sides
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    send_random_strings(115);

    in_ch.valid <= 1'b0;
    while (board.expected_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d input beats (%0d random), %0d result beats checked",
             board.beats_in, random_beats, board.beats_out);
    $display("  %0d entities decoded, %0d malformed escapes, %0d mismatches",
             board.decoded_entities, board.bad_escapes, board.mismatches);
    if (board.mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
